@@ design/sdss_pkg.sv @@
// Shared constants for the stable descending score sort unit.
package sdss_pkg;

	localparam int SQ_BITS             = 6;
	localparam int PROMO_BITS          = 3;
	localparam int MAX_ENTRIES_DEFAULT = 64;
	localparam int SCORE_BITS_DEFAULT  = 16;

endpackage

@@ design/sdss_ram.sv @@
// Generic single write port RAM with one registered read port.
module sdss_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ design/stable_descending_score_sort_unit.sv @@
// Load one entry per transfer, keep them sorted by score in RAM, emit on the last entry.
// Load: an entry goes straight into an empty store, else stored entries with a strictly
//   lower score shift down; each shifted entry costs one read-compare-write of the RAM.
// Emit: once the last entry's load finishes, each result passes the registered RAM read and
//   then the output register; the next result is loaded only after the current one is taken.
// Reset clears count, drop flag, sequencer and output valid; RAM contents stay undefined.
module stable_descending_score_sort_unit #(
	parameter int MAX_ENTRIES = sdss_pkg::MAX_ENTRIES_DEFAULT,
	parameter int SCORE_BITS  = sdss_pkg::SCORE_BITS_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [sdss_pkg::SQ_BITS-1:0]    from_square,
	input  logic [sdss_pkg::SQ_BITS-1:0]    to_square,
	input  logic [sdss_pkg::PROMO_BITS-1:0] promotion,
	input  logic signed [SCORE_BITS-1:0]   score,
	input  logic                           last,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [sdss_pkg::SQ_BITS-1:0]    out_from,
	output logic [sdss_pkg::SQ_BITS-1:0]    out_to,
	output logic [sdss_pkg::PROMO_BITS-1:0] out_promotion,
	output logic signed [SCORE_BITS-1:0]   out_score,
	output logic                           out_last,
	output logic                           overflowed
);

	localparam int SQ = sdss_pkg::SQ_BITS;
	localparam int PB = sdss_pkg::PROMO_BITS;
	localparam int EW = 2 * SQ + PB + SCORE_BITS;
	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(MAX_ENTRIES);
	localparam logic [CW-1:0] CNT_ONE  = CW'(1);
	localparam logic [AW-1:0] ADDR_ONE = AW'(1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SHIFT = 3'd1;
	localparam logic [2:0] ST_PLACE = 3'd2;
	localparam logic [2:0] ST_EM_RD = 3'd3;
	localparam logic [2:0] ST_EM_LD = 3'd4;
	localparam logic [2:0] ST_EM_WT = 3'd5;

	logic [2:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic          drop_q;
	logic          last_q;
	logic [AW-1:0] pos_q;
	logic [AW-1:0] k_q;
	logic [EW-1:0] entry_q;
	logic          valid_q;

	logic [SQ-1:0]         out_from_q;
	logic [SQ-1:0]         out_to_q;
	logic [PB-1:0]         out_promo_q;
	logic [SCORE_BITS-1:0] out_score_q;
	logic                  out_last_q;
	logic                  overflowed_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [EW-1:0] ram_rdata;

	logic          in_xfer;
	logic          out_xfer;
	logic [EW-1:0] in_entry;
	logic          lower;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = valid_q && !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign in_entry = {from_square, to_square, promotion, score};
	assign lower    = $signed(ram_rdata[SCORE_BITS-1:0]) < $signed(entry_q[SCORE_BITS-1:0]);

	sdss_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_ENTRIES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = entry_q;
		ram_raddr = pos_q - ADDR_ONE;
		unique case (state_q)
			ST_IDLE: begin
				ram_waddr = '0;
				ram_wdata = in_entry;
				ram_raddr = AW'(cnt_q - CNT_ONE);
				ram_we    = in_xfer && (cnt_q == '0);
			end
			ST_SHIFT: begin
				// move the lower entry down one place and fetch the next one up
				ram_we    = 1'b1;
				ram_wdata = lower ? ram_rdata : entry_q;
				ram_raddr = pos_q - AW'(2);
			end
			ST_PLACE: begin
				ram_we = 1'b1;
			end
			ST_EM_RD: begin
				ram_raddr = k_q;
			end
			ST_EM_LD: begin
				ram_raddr = k_q;
			end
			ST_EM_WT: begin
				ram_raddr = k_q + ADDR_ONE;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			drop_q  <= 1'b0;
			last_q  <= 1'b0;
			pos_q   <= '0;
			k_q     <= '0;
			valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						last_q <= last;
						pos_q  <= cnt_q[AW-1:0];
						k_q    <= '0;
						if (cnt_q == CNT_FULL) begin
							drop_q  <= 1'b1;
							state_q <= last ? ST_EM_RD : ST_IDLE;
						end else if (cnt_q == '0) begin
							cnt_q   <= CNT_ONE;
							state_q <= last ? ST_EM_RD : ST_IDLE;
						end else begin
							state_q <= ST_SHIFT;
						end
					end
				end
				ST_SHIFT: begin
					if (lower) begin
						pos_q <= pos_q - ADDR_ONE;
						if (pos_q == ADDR_ONE) begin
							state_q <= ST_PLACE;
						end
					end else begin
						cnt_q   <= cnt_q + CNT_ONE;
						state_q <= last_q ? ST_EM_RD : ST_IDLE;
					end
				end
				ST_PLACE: begin
					cnt_q   <= cnt_q + CNT_ONE;
					state_q <= last_q ? ST_EM_RD : ST_IDLE;
				end
				ST_EM_RD: begin
					state_q <= ST_EM_LD;
				end
				ST_EM_LD: begin
					valid_q <= 1'b1;
					state_q <= ST_EM_WT;
				end
				ST_EM_WT: begin
					if (out_xfer) begin
						valid_q <= 1'b0;
						if (out_last_q) begin
							cnt_q   <= '0;
							drop_q  <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + ADDR_ONE;
							state_q <= ST_EM_LD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_xfer) begin
			entry_q <= in_entry;
		end
		if (state_q == ST_EM_LD) begin
			out_from_q   <= ram_rdata[EW-1 -: SQ];
			out_to_q     <= ram_rdata[EW-SQ-1 -: SQ];
			out_promo_q  <= ram_rdata[SCORE_BITS+PB-1 -: PB];
			out_score_q  <= ram_rdata[SCORE_BITS-1:0];
			out_last_q   <= (CW'(k_q) + CNT_ONE) == cnt_q;
			overflowed_q <= drop_q;
		end
	end

	assign out_valid     = valid_q;
	assign out_from      = out_from_q;
	assign out_to        = out_to_q;
	assign out_promotion = out_promo_q;
	assign out_score     = out_score_q;
	assign out_last      = out_last_q;
	assign overflowed    = overflowed_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("entry count beyond capacity");

	a_out_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> cnt_q != '0)
		else $error("result shown from an empty store");

	a_list_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && out_last_q |=> cnt_q == '0 && !drop_q && state_q == ST_IDLE)
		else $error("list state not cleared after final transfer");

	a_shift_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SHIFT |-> pos_q != '0 && CW'(pos_q) <= cnt_q && cnt_q != CNT_FULL)
		else $error("insertion position out of range");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(drop_q) |-> $past(cnt_q) == CNT_FULL)
		else $error("drop flagged with room left");
`endif

endmodule

@@ sim/tb_stable_descending_score_sort_unit.sv @@
// Self-checking testbench for the stable descending score sort unit.
module tb_stable_descending_score_sort_unit;

	localparam int SCORE_W  = sdss_pkg::SCORE_BITS_DEFAULT;
	localparam int CAPACITY = sdss_pkg::MAX_ENTRIES_DEFAULT;
	localparam int SQ_W     = sdss_pkg::SQ_BITS;
	localparam int PROMO_W  = sdss_pkg::PROMO_BITS;

	localparam logic [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
	localparam logic [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

	typedef enum int {SCORE_ANY, SCORE_TIES, SCORE_EXTREME} score_mix_t;

	typedef struct packed {
		logic [SQ_W-1:0]    src;
		logic [SQ_W-1:0]    dst;
		logic [PROMO_W-1:0] promo;
		logic [SCORE_W-1:0] score;
	} move_t;

	typedef struct packed {
		move_t mv;
		logic  is_final;
		logic  lost;
	} ranked_move_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [SQ_W-1:0] from_square;
	logic [SQ_W-1:0] to_square;
	logic [PROMO_W-1:0] promotion;
	logic signed [SCORE_W-1:0] score;
	logic last;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [SQ_W-1:0] out_from;
	logic [SQ_W-1:0] out_to;
	logic [PROMO_W-1:0] out_promotion;
	logic signed [SCORE_W-1:0] out_score;
	logic out_last;
	logic overflowed;

	// predictor state: the list being loaded, kept in output order
	move_t        loaded_moves[$];
	logic         moves_dropped;
	ranked_move_t ranked_expected[$];

	int send_idle_pct;
	int recv_stall_pct;
	int n_errors;
	int n_entries;
	int n_lists;
	int n_overflow_lists;
	int n_ranked;

	stable_descending_score_sort_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.from_square  (from_square),
		.to_square    (to_square),
		.promotion    (promotion),
		.score        (score),
		.last         (last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_from     (out_from),
		.out_to       (out_to),
		.out_promotion(out_promotion),
		.out_score    (out_score),
		.out_last     (out_last),
		.overflowed   (overflowed)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#(8 * 400000);
		$display("tb_stable_descending_score_sort_unit NOT OK");
		$finish;
	end

	// Insert stably: the new move goes below every move with an equal or higher score.
	task automatic rank_transfer(input move_t m, input logic is_last);
		int pos;
		ranked_move_t r;
		n_entries++;
		if (loaded_moves.size() < CAPACITY) begin
			pos = loaded_moves.size();
			while (pos > 0 && $signed(loaded_moves[pos-1].score) < $signed(m.score))
				pos--;
			loaded_moves.insert(pos, m);
		end else begin
			moves_dropped = 1'b1;
		end
		if (is_last) begin
			for (int k = 0; k < loaded_moves.size(); k++) begin
				r.mv       = loaded_moves[k];
				r.is_final = (k == loaded_moves.size() - 1);
				r.lost     = moves_dropped;
				ranked_expected.insert(ranked_expected.size(), r);
			end
			n_lists++;
			if (moves_dropped)
				n_overflow_lists++;
			loaded_moves.delete();
			moves_dropped = 1'b0;
		end
	endtask

	task automatic send_entry(input move_t m, input logic is_last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		from_square <= m.src;
		to_square   <= m.dst;
		promotion   <= m.promo;
		score       <= m.score;
		last        <= is_last;
		do
			@(posedge clk);
		while (in_stall);
		rank_transfer(m, is_last);
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (ranked_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	function automatic move_t build_move(input int s, input int d, input int p, input int sc);
		move_t m;
		m.src   = s[SQ_W-1:0];
		m.dst   = d[SQ_W-1:0];
		m.promo = p[PROMO_W-1:0];
		m.score = sc[SCORE_W-1:0];
		return m;
	endfunction

	function automatic move_t random_move(input score_mix_t mix);
		move_t m;
		int tie;
		m.src   = SQ_W'($urandom_range(63));
		m.dst   = SQ_W'($urandom_range(63));
		m.promo = PROMO_W'($urandom_range(7));
		tie     = $urandom_range(4);
		case (mix)
			SCORE_TIES: m.score = SCORE_W'(tie - 2);
			SCORE_EXTREME: begin
				case ($urandom_range(3))
					0: m.score = SCORE_MIN;
					1: m.score = SCORE_MAX;
					2: m.score = '0;
					default: m.score = '1;
				endcase
			end
			default: m.score = SCORE_W'($urandom);
		endcase
		return m;
	endfunction

	task automatic check_field(input string fname, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (want !== got) begin
			n_errors++;
			$display("%0t: mismatch on %s, expected %0d, actual %0d", $time, fname, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		ranked_move_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (ranked_expected.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected result, expected none, actual score %0d from %0d to %0d",
					$time, out_score, out_from, out_to);
			end else begin
				want = ranked_expected.pop_front();
				check_field("out_from", 32'(want.mv.src), 32'(out_from));
				check_field("out_to", 32'(want.mv.dst), 32'(out_to));
				check_field("out_promotion", 32'(want.mv.promo), 32'(out_promotion));
				check_field("out_score", 32'($signed(want.mv.score)), 32'(out_score));
				check_field("out_last", 32'(want.is_final), 32'(out_last));
				check_field("overflowed", 32'(want.lost), 32'(overflowed));
				n_ranked++;
			end
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic test_single_entry();
		send_entry(build_move(0, 0, 0, 0), 1'b1);
		send_entry(build_move(63, 63, 7, -32768), 1'b1);
	endtask

	task automatic test_field_extremes();
		send_entry(build_move(63, 0, 5, 32767), 1'b0);
		send_entry(build_move(0, 63, 7, -32768), 1'b0);
		send_entry(build_move(42, 21, 6, -1), 1'b0);
		send_entry(build_move(21, 42, 0, 0), 1'b0);
		send_entry(build_move(1, 2, 3, 1), 1'b1);
	endtask

	// Equal scores must leave in arrival order around higher and lower neighbors.
	task automatic test_equal_scores();
		send_entry(build_move(10, 11, 0, 100), 1'b0);
		send_entry(build_move(12, 13, 1, 100), 1'b0);
		send_entry(build_move(14, 15, 2, -5), 1'b0);
		send_entry(build_move(16, 17, 3, 100), 1'b0);
		send_entry(build_move(18, 19, 4, 100), 1'b0);
		send_entry(build_move(20, 22, 5, 200), 1'b1);
	endtask

	// Rising scores push every stored entry down on each arrival.
	task automatic test_ascending_scores();
		for (int i = 0; i < 8; i++)
			send_entry(build_move(i, 63 - i, i % 6, i * 4000 - 16000), i == 7);
	endtask

	task automatic test_full_store();
		for (int i = 0; i < CAPACITY; i++)
			send_entry(random_move(SCORE_TIES), i == CAPACITY - 1);
		// two more than fit: the entry carrying last is dropped as well
		for (int i = 0; i < CAPACITY + 2; i++)
			send_entry(random_move(score_mix_t'($urandom_range(2))), i == CAPACITY + 1);
	endtask

	task automatic test_random_lists(input int budget);
		int sent;
		int len;
		score_mix_t mix;
		sent = 0;
		while (sent < budget) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			mix = score_mix_t'($urandom_range(2));
			for (int i = 0; i < len; i++)
				send_entry(random_move(mix), i == len - 1);
			sent += len;
		end
	endtask

	initial begin
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		from_square <= '0;
		to_square   <= '0;
		promotion   <= '0;
		score       <= '0;
		last        <= 1'b0;
		moves_dropped = 1'b0;
		n_errors = 0;
		n_entries = 0;
		n_lists = 0;
		n_overflow_lists = 0;
		n_ranked = 0;
		set_idling(33, 68);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_entry();
		test_field_extremes();
		test_equal_scores();
		test_ascending_scores();
		wait_for_drain();
		test_full_store();
		test_random_lists(60);
		wait_for_drain();
		set_idling(68, 33);
		test_random_lists(60);
		wait_for_drain();
		set_idling(0, 0);
		test_random_lists(50);
		wait_for_drain();
		// let any stray result show up
		repeat (40) @(posedge clk);

		$display("Sorted %0d lists from %0d entries, %0d lists past capacity.",
			n_lists, n_entries, n_overflow_lists);
		$display("Checked %0d results under three sender/receiver stall mixes, %0d errors.",
			n_ranked, n_errors);
		if (n_errors == 0)
			$display("tb_stable_descending_score_sort_unit OK");
		else
			$display("tb_stable_descending_score_sort_unit NOT OK");
		$finish;
	end

endmodule
